// File: rtl/swks_pkg.sv
// shared constants and types for the six-axis wrench smoother
package swks_pkg;

    localparam int NUM_AXES = 6;
    localparam int AXIS_W   = 32;
    localparam int IDX_W    = 3;

    // Q2.30 constants
    localparam logic [31:0] ONE_Q30    = 32'd1073741824;
    localparam logic [31:0] PROC_NOISE = 32'd10737;

    // ten newtons in Q16.16
    localparam logic [31:0] TEN_NEWTONS = 32'd655360;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_ENABLE    = 3'd0;
    localparam logic [IDX_W-1:0] REG_OFFSET_TZ = 3'd6;

    typedef logic signed [AXIS_W-1:0] t_axis_arr [NUM_AXES];

    // measurement noise per axis, Q2.30
    function automatic logic [31:0] meas_noise(input int axis);
        logic [31:0] r;
        case (axis)
            0:       r = 32'd937802;
            1:       r = 32'd1076705;
            2:       r = 32'd85700330;
            3:       r = 32'd56870;
            4:       r = 32'd34518;
            default: r = 32'd15097;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/six_axis_wrench_kalman_smoother_unit.sv
// top level: six kalman lanes, offset merge, saturation and output register
//
// One wrench sample is taken at a time. With filtering on, the six axes run in
// parallel lanes, each with its own bit-serial gain divider (31 steps); with
// filtering off the captured raw sample goes straight to the merge stage. A
// finished result waits in the merge stage while the output register still
// holds an unaccepted result. The next sample is taken as soon as the previous
// result has moved into the output register. Over-range bits flag raw values
// strictly above the force or torque limit.
module six_axis_wrench_kalman_smoother_unit
    import swks_pkg::*;
#(
    parameter logic [31:0] FORCE_RANGE  = 32'd13107200,
    parameter logic [31:0] TORQUE_RANGE = 32'd655360
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic signed [31:0]       i_sample_fx,
    input  logic signed [31:0]       i_sample_fy,
    input  logic signed [31:0]       i_sample_fz,
    input  logic signed [31:0]       i_sample_tx,
    input  logic signed [31:0]       i_sample_ty,
    input  logic signed [31:0]       i_sample_tz,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [31:0]       o_filtered_fx,
    output logic signed [31:0]       o_filtered_fy,
    output logic signed [31:0]       o_filtered_fz,
    output logic signed [31:0]       o_filtered_tx,
    output logic signed [31:0]       o_filtered_ty,
    output logic signed [31:0]       o_filtered_tz,
    output logic [5:0]               o_over_range,
    input  logic                     i_cfg_we,
    input  logic [IDX_W-1:0]         i_cfg_index,
    input  logic [31:0]              i_cfg_data
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_MERGE = 2'd2;

    logic [1:0]  r_state;
    logic        r_enable;
    t_axis_arr   r_offset;
    t_axis_arr   r_raw;
    logic [5:0]  r_mask;
    logic        r_out_valid;
    t_axis_arr   r_out;
    logic [5:0]  r_out_mask;

    t_axis_arr   n_sample;
    t_axis_arr   w_est;
    t_axis_arr   n_out;
    logic [5:0]  n_mask;
    logic [5:0]  w_done;
    logic        w_accept;
    logic        w_start;
    logic        w_merge;

    assign n_sample[0] = i_sample_fx;
    assign n_sample[1] = i_sample_fy;
    assign n_sample[2] = i_sample_fz;
    assign n_sample[3] = i_sample_tx;
    assign n_sample[4] = i_sample_ty;
    assign n_sample[5] = i_sample_tz;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_start    = w_accept && r_enable;
    assign w_merge    = (r_state == ST_MERGE) && (!r_out_valid || !i_out_stall);

    // over-range flags and lanes
    genvar g;
    generate
        for (g = 0; g < NUM_AXES; g++) begin : g_lane
            if (g < 3) begin : g_force
                assign n_mask[g] = (n_sample[g] > $signed(FORCE_RANGE));
            end else begin : g_torque
                assign n_mask[g] = (n_sample[g] > $signed(TORQUE_RANGE));
            end
            swks_lane #(.AXIS(g)) u_lane (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_start    (w_start),
                .i_sample   (n_sample[g]),
                .o_done     (w_done[g]),
                .o_estimate (w_est[g])
            );
        end
    endgenerate

    // merge: offset (filtering on only), ten newton shift on z, saturate
    always_comb begin
        logic signed [33:0] v;
        for (int a = 0; a < NUM_AXES; a++) begin
            v = r_enable ? ($signed({{2{w_est[a][31]}}, w_est[a]}) -
                            $signed({{2{r_offset[a][31]}}, r_offset[a]}))
                         : $signed({{2{r_raw[a][31]}}, r_raw[a]});
            if (a == 2) begin
                v = v - $signed({2'b0, TEN_NEWTONS});
            end
            if (v > $signed(34'sh07FFFFFFF)) begin
                n_out[a] = 32'sh7FFFFFFF;
            end else if (v < $signed(-34'sh080000000)) begin
                n_out[a] = 32'sh80000000;
            end else begin
                n_out[a] = v[31:0];
            end
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            for (int a = 0; a < NUM_AXES; a++) begin
                r_offset[a] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_ENABLE) begin
                r_enable <= i_cfg_data[0];
            end else if (i_cfg_index <= REG_OFFSET_TZ) begin
                r_offset[i_cfg_index - 3'd1] <= i_cfg_data;
            end
        end
    end

    // control and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_merge) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= r_enable ? ST_RUN : ST_MERGE;
                    end
                end
                ST_RUN: begin
                    if (&w_done) begin
                        r_state <= ST_MERGE;
                    end
                end
                ST_MERGE: begin
                    if (w_merge) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // payload capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_raw  <= n_sample;
            r_mask <= n_mask;
        end
        if (w_merge) begin
            r_out      <= n_out;
            r_out_mask <= r_mask;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_filtered_fx = r_out[0];
    assign o_filtered_fy = r_out[1];
    assign o_filtered_fz = r_out[2];
    assign o_filtered_tx = r_out[3];
    assign o_filtered_ty = r_out[4];
    assign o_filtered_tz = r_out[5];
    assign o_over_range  = r_out_mask;

endmodule

// File: rtl/swks_lane.sv
// one axis of the scalar kalman update: serial gain divider, split multiply, state update
module swks_lane
    import swks_pkg::*;
#(
    parameter int AXIS = 0
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [AXIS_W-1:0] i_sample,
    output logic                     o_done,
    output logic signed [AXIS_W-1:0] o_estimate
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_MUL  = 2'd2;
    localparam logic [1:0] S_UPD  = 2'd3;
    localparam logic [31:0] R_NOISE = meas_noise(AXIS);

    logic [1:0]         r_state;
    logic [4:0]         r_cnt;
    logic signed [31:0] r_est;
    logic [31:0]        r_var;
    logic [31:0]        r_pp;
    logic [31:0]        r_div;
    logic [32:0]        r_rem;
    logic [30:0]        r_dnd;
    logic [30:0]        r_q;
    logic signed [32:0] r_diff;
    logic signed [48:0] r_ph;
    logic [46:0]        r_pl;
    logic [62:0]        r_pv;

    logic [31:0]        n_pp;
    logic [32:0]        n_rem_sh;
    logic               n_qbit;
    logic signed [65:0] n_prod;
    logic signed [35:0] n_est;

    // divider step and update arithmetic
    always_comb begin
        n_pp     = r_var + PROC_NOISE;
        n_rem_sh = {r_rem[31:0], r_dnd[30]};
        n_qbit   = (n_rem_sh >= {1'b0, r_div});
        n_prod   = $signed({r_ph[48], r_ph, 16'b0}) + $signed({19'b0, r_pl});
        n_est    = $signed({{4{r_est[31]}}, r_est}) + $signed(n_prod[65:30]);
    end

    // lane sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_est   <= '0;
            r_var   <= ONE_Q30;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_pp    <= n_pp;
                        r_div   <= n_pp + R_NOISE;
                        r_rem   <= {2'b0, n_pp[31:1]};
                        r_dnd   <= {n_pp[0], 30'b0};
                        r_q     <= '0;
                        r_cnt   <= '0;
                        r_diff  <= $signed({i_sample[31], i_sample}) -
                                   $signed({r_est[31], r_est});
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= n_qbit ? (n_rem_sh - {1'b0, r_div}) : n_rem_sh;
                    r_dnd <= {r_dnd[29:0], 1'b0};
                    r_q   <= {r_q[29:0], n_qbit};
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd30) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_ph    <= $signed({1'b0, r_q}) * $signed(r_diff[32:16]);
                    r_pl    <= r_q * r_diff[15:0];
                    r_pv    <= (ONE_Q30[30:0] - r_q) * r_pp;
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_est   <= n_est[31:0];
                    r_var   <= r_pv[61:30];
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done     = (r_state == S_UPD);
    assign o_estimate = r_est;

endmodule
